>>> hw/rtl/binary_gcd_core_defines.svh
// Assertion macros for the binary GCD core checker.
`ifndef BINARY_GCD_CORE_DEFINES_SVH
`define BINARY_GCD_CORE_DEFINES_SVH

// Same-cycle implication, reset disables.
`define BGCD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("binary_gcd_core: check failed");

// Next-cycle implication, reset disables.
`define BGCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("binary_gcd_core: check failed");

// Next-cycle implication, checked during reset as well.
`define BGCD_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("binary_gcd_core: check failed");

`endif

>>> hw/rtl/bgcd_pkg.sv
package bgcd_pkg;

    localparam int DATA_W = 64;

    typedef logic [2:0] op_t;

    localparam op_t OP_HOLD    = 3'd0;
    localparam op_t OP_LOAD    = 3'd1;
    localparam op_t OP_STRIP   = 3'd2;
    localparam op_t OP_HALVE_A = 3'd3;
    localparam op_t OP_HALVE_B = 3'd4;
    localparam op_t OP_REDUCE  = 3'd5;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
    } status_t;

endpackage

>>> hw/rtl/bgcd_datapath.sv
module bgcd_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                  aclk,
    input  bgcd_pkg::op_t         op,
    input  logic [WIDTH-1:0]      load_a,
    input  logic [WIDTH-1:0]      load_b,
    output bgcd_pkg::status_t     status,
    output logic [WIDTH-1:0]      result
);
    import bgcd_pkg::*;

    localparam int TWOS_W = $clog2(WIDTH);

    logic [WIDTH-1:0]  a_reg, a_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic [TWOS_W-1:0] twos_reg, twos_next;
    logic [WIDTH:0]    diff_ba;
    logic [WIDTH-1:0]  diff_ab;

    assign diff_ba = {1'b0, b_reg} - {1'b0, a_reg};
    assign diff_ab = a_reg - b_reg;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        twos_next = twos_reg;
        case (op)
            OP_LOAD: begin
                a_next    = load_a;
                b_next    = load_b;
                twos_next = '0;
            end
            OP_STRIP: begin
                a_next    = a_reg >> 1;
                b_next    = b_reg >> 1;
                twos_next = twos_reg + TWOS_W'(1);
            end
            OP_HALVE_A: a_next = a_reg >> 1;
            OP_HALVE_B: b_next = b_reg >> 1;
            OP_REDUCE: begin
                if (diff_ba[WIDTH]) begin
                    a_next = b_reg;
                    b_next = diff_ab;
                end else begin
                    b_next = diff_ba[WIDTH-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        twos_reg <= twos_next;
    end

    assign status.a_zero = (a_reg == '0);
    assign status.b_zero = (b_reg == '0);
    assign status.a_odd  = a_reg[0];
    assign status.b_odd  = b_reg[0];

    assign result = (a_reg | b_reg) << twos_reg;

endmodule

>>> hw/rtl/binary_gcd_core.sv
// Binary GCD core, one pair at a time through a shared shift/subtract unit.
// Steps: load, strip common twos, halve a to odd, then halve b or subtract until b is zero;
// a zero operand skips to the finish, which waits while an unread result is held back by m_ready.
// A new pair is taken only after the last one finishes; s_ready is high only while the sequencer idles.
// The result waits in an output register, so the next pair enters while it is pending.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_valid.
module binary_gcd_core #(
    parameter int WIDTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bgcd_pkg::DATA_W-1:0] s_operand_a,
    input  logic [bgcd_pkg::DATA_W-1:0] s_operand_b,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bgcd_pkg::DATA_W-1:0] m_divisor
);
    import bgcd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STRIP  = 3'd1;
    localparam logic [2:0] ST_NORM   = 3'd2;
    localparam logic [2:0] ST_REDUCE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] divisor_reg;
    logic              out_load;
    op_t               op;
    status_t           status;
    logic [WIDTH-1:0]  result;

    bgcd_datapath #(.WIDTH(WIDTH)) u_datapath (
        .aclk   (aclk),
        .op     (op),
        .load_a (s_operand_a[WIDTH-1:0]),
        .load_b (s_operand_b[WIDTH-1:0]),
        .status (status),
        .result (result)
    );

    always_comb begin
        state_next = state_reg;
        op         = OP_HOLD;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (status.a_zero || status.b_zero) begin
                    state_next = ST_FINISH;
                end else if (!status.a_odd && !status.b_odd) begin
                    op = OP_STRIP;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (!status.a_odd) begin
                    op = OP_HALVE_A;
                end else begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.b_zero) begin
                    state_next = ST_FINISH;
                end else if (!status.b_odd) begin
                    op = OP_HALVE_B;
                end else begin
                    op = OP_REDUCE;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            divisor_reg <= DATA_W'(result);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_divisor = divisor_reg;

endmodule

>>> hw/rtl/bgcd_checker.sv
`include "binary_gcd_core_defines.svh"

module bgcd_checker #(
    parameter int WIDTH = 64
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [bgcd_pkg::DATA_W-1:0] s_operand_a,
    input logic [bgcd_pkg::DATA_W-1:0] s_operand_b,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bgcd_pkg::DATA_W-1:0] m_divisor
);
    import bgcd_pkg::*;

    logic s_accept;
    logic zero_pair;

    assign s_accept  = s_valid && s_ready;
    assign zero_pair = (s_operand_a[WIDTH-1:0] == '0) && (s_operand_b[WIDTH-1:0] == '0);

    `BGCD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_divisor))
    `BGCD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_ready)
    `BGCD_ASSERT_IMPL(a_zero_pair, aclk, aresetn, s_accept && zero_pair && !m_valid, ##3 (m_valid && m_divisor == '0))
    `BGCD_ASSERT_IMPL(a_upper_clear, aclk, aresetn, m_valid, (m_divisor >> WIDTH) == '0)
    `BGCD_ASSERT_ALWAYS(a_reset_drop, aclk, !aresetn, !m_valid)

endmodule

bind binary_gcd_core bgcd_checker #(.WIDTH(WIDTH)) u_bgcd_checker (.*);

>>> sim/binary_gcd_core_tb.sv
`timescale 1ns / 1ps

module binary_gcd_core_tb;

    import bgcd_pkg::*;

    localparam int W = 64;
    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - W);
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] TOP_BIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int RANDOM_PAIRS = 1830;
    localparam int QUIET_FIRST = 500;
    localparam int QUIET_LAST = 800;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } operand_pair_t;

    logic aclk;
    logic aresetn;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [DATA_W-1:0] s_operand_a = '0;
    logic [DATA_W-1:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DATA_W-1:0] m_divisor;

    operand_pair_t pair_q[$];
    logic [DATA_W-1:0] gcd_q[$];
    operand_pair_t next_pair;
    logic [DATA_W-1:0] want_gcd;
    int words_in = 0;
    int failures = 0;

    binary_gcd_core #(
        .WIDTH(W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operand_a(s_operand_a),
        .s_operand_b(s_operand_b),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_divisor(m_divisor)
    );

    function automatic logic [DATA_W-1:0] euclid_gcd(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] r;
        x = a & WORD_MASK;
        y = b & WORD_MASK;
        while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x & WORD_MASK;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DATA_W-1:0] rand_narrow(int min_shift);
        return rand_word() >> $urandom_range(63, min_shift);
    endfunction

    function automatic int idle_pct();
        if (words_in >= QUIET_FIRST && words_in < QUIET_LAST) begin
            return 0;
        end
        return 33;
    endfunction

    task automatic add_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        operand_pair_t p;
        p.a = a;
        p.b = b;
        pair_q = {pair_q, p};
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hold the word until taken, then load the next one or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                gcd_q = {gcd_q, euclid_gcd(s_operand_a, s_operand_b)};
                words_in++;
            end
            if (!s_valid || s_ready) begin
                if (pair_q.size() != 0 && $urandom_range(99) >= idle_pct()) begin
                    next_pair = pair_q.pop_front();
                    s_operand_a <= next_pair.a;
                    s_operand_b <= next_pair.b;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (gcd_q.size() == 0) begin
                    $display("%0t: divisor %h with none expected", $time, m_divisor);
                    failures++;
                end else begin
                    want_gcd = gcd_q.pop_front();
                    if (m_divisor !== want_gcd) begin
                        $display("%0t: divisor mismatch, expected %h, actual %h",
                                 $time, want_gcd, m_divisor);
                        failures++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct());
        end
    end

    initial begin
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        int k;
        aresetn = 1'b0;

        add_pair('0, '0);
        add_pair('0, ALL_ONES);
        add_pair(ALL_ONES, '0);
        add_pair('0, 64'd1);
        add_pair(64'd1, '0);
        add_pair(ALL_ONES, ALL_ONES);
        add_pair(64'd1, 64'd1);
        add_pair(64'd1, ALL_ONES);
        add_pair(ALL_ONES, ALL_ONES - 64'd1);
        add_pair(TOP_BIT, TOP_BIT);
        add_pair(TOP_BIT, TOP_BIT >> 1);
        add_pair(TOP_BIT, 64'd1);
        add_pair(TOP_BIT, ALL_ONES);
        add_pair(TOP_BIT, 64'd3 << 40);
        add_pair(64'd7540113804746346429, 64'd12200160415121876738);
        add_pair(64'd18446744073709551557, 64'd18446744073709551533);
        add_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        add_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        add_pair(64'd48, 64'd18);
        add_pair(64'd1, TOP_BIT - 64'd1);
        add_pair(64'd6 << 50, 64'd9 << 52);
        add_pair(64'hFFFF_FFFF, 64'h1_0000_0001);

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            case ($urandom_range(9)) inside
                [0:1]: begin
                    x = rand_word();
                    y = rand_word();
                end
                2: begin
                    x = rand_narrow(32);
                    y = x * rand_narrow(33);
                    x = x * rand_narrow(33);
                end
                3: begin
                    k = int'($urandom_range(63));
                    x = rand_word() << k;
                    y = rand_word() << k;
                end
                4: begin
                    x = rand_narrow(0);
                    y = '0;
                    if ($urandom_range(1)) begin
                        y = x;
                        x = '0;
                    end
                end
                5: begin
                    x = DATA_W'($urandom_range(255));
                    y = DATA_W'($urandom_range(255));
                end
                6: begin
                    x = rand_narrow(16);
                    y = x * DATA_W'($urandom_range(1, 65535));
                end
                7: begin
                    x = rand_narrow(0);
                    y = rand_narrow(0);
                end
                8: begin
                    x = 64'd1 << $urandom_range(63);
                    y = rand_word();
                end
                default: begin
                    x = rand_word();
                    y = $urandom_range(1) ? x + 64'd1 : x - 64'd1;
                end
            endcase
            if ($urandom_range(1)) begin
                add_pair(x, y);
            end else begin
                add_pair(y, x);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_valid) @(posedge aclk);
        while (gcd_q.size() != 0) @(posedge aclk);
        repeat (3 * W + 16) @(posedge aclk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #13_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
